// ===== rtl/core/moving_average_filter_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the moving average filter core
// Shared wrappers for the concurrent checks on the core's ports.
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_FILTER_CORE_ASSERT_SVH
`define MOVING_AVERAGE_FILTER_CORE_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle
`define MAF_ASSERT_IMPL(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("moving average filter check failed");

// Check that a condition implies a consequence in the next cycle
`define MAF_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("moving average filter check failed");

`endif

// ===== rtl/core/maf_pkg.sv =====
// ----------------------------------------------------------------------------
// Moving average filter package
// Window size, derived widths and the job word passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package maf_pkg;

  // Number of samples averaged once the ring is full
  localparam int unsigned WINDOW = 16;

  // Sample and average widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned AVG_W    = 16;

  // Running sum holds up to WINDOW full-scale samples
  localparam int unsigned SUM_W  = $clog2(WINDOW * ((2 ** SAMPLE_W) - 1) + 1);
  // Fill count runs 0 .. WINDOW
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  // Ring slot index
  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // Job queue between front and divider
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Divider step counter
  localparam int unsigned STEP_W = $clog2(SUM_W);

  // One division job: dividend and divisor
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
  } job_t;

endpackage

`default_nettype wire

// ===== rtl/core/maf_front.sv =====
// ----------------------------------------------------------------------------
// Moving average filter front end
// Takes samples, updates the sample ring, running sum and fill count, and
// issues one division job per sample.
// ----------------------------------------------------------------------------
`default_nettype none

module maf_front
  import maf_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [SAMPLE_W-1:0] sample_i,
  input  wire logic                sample_valid_i,
  output logic                     sample_ready_o,
  output job_t                     job_o,
  output logic                     job_valid_o,
  input  wire logic                job_ready_i
);

  typedef enum logic {
    FRONT_IDLE,
    FRONT_PUSH
  } front_state_e;

  front_state_e          state_q;
  logic [SLOT_W-1:0]     slot_q, slot_d;
  logic [CNT_W-1:0]      fill_q, fill_d;
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [SAMPLE_W-1:0]   sample_q;
  logic [SAMPLE_W-1:0]   evict_q;
  logic [SAMPLE_W-1:0]   evict;
  logic [SAMPLE_W-1:0]   ring_mem [WINDOW];
  logic                  ring_full;
  logic                  take;
  logic                  push;

  assign sample_ready_o = (state_q == FRONT_IDLE);
  assign take           = sample_valid_i && sample_ready_o;
  assign job_valid_o    = (state_q == FRONT_PUSH);
  assign push           = job_valid_o && job_ready_i;

  // Entries beyond the fill count were never written; evict is masked to zero until the ring is full
  assign ring_full = (fill_q == CNT_W'(WINDOW));
  assign evict     = ring_full ? evict_q : '0;

  // Evict the old entry, add the new sample
  assign sum_d  = sum_q - SUM_W'(evict) + SUM_W'(sample_q);
  assign fill_d = ring_full ? fill_q : fill_q + CNT_W'(1);
  assign slot_d = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);

  assign job_o.sum = sum_d;
  assign job_o.cnt = fill_d;

  // Ring memory: read the slot to evict on accept, write the sample on push
  always_ff @(posedge clk_i) begin
    if (take) begin
      evict_q  <= ring_mem[slot_q];
      sample_q <= sample_i;
    end
    if (push) begin
      ring_mem[slot_q] <= sample_q;
    end
  end

  // Sequence the front and advance the ring state on push
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FRONT_IDLE;
      slot_q  <= '0;
      fill_q  <= '0;
      sum_q   <= '0;
    end else begin
      case (state_q)
        FRONT_IDLE: begin
          if (take) begin
            state_q <= FRONT_PUSH;
          end
        end
        FRONT_PUSH: begin
          if (push) begin
            state_q <= FRONT_IDLE;
            slot_q  <= slot_d;
            fill_q  <= fill_d;
            sum_q   <= sum_d;
          end
        end
        default: begin
          state_q <= FRONT_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/maf_queue.sv =====
// ----------------------------------------------------------------------------
// Moving average filter job queue
// Short FIFO of division jobs between the front end and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module maf_queue
  import maf_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  job_t      wr_job_i,
  input  wire logic wr_valid_i,
  output logic      wr_ready_o,
  output job_t      rd_job_o,
  output logic      rd_valid_o,
  input  wire logic rd_ready_i
);

  job_t               slot_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q;
  logic [Q_PTR_W-1:0] rd_ptr_q;
  logic [Q_CNT_W-1:0] count_q;
  logic               wr_en;
  logic               rd_en;

  assign wr_ready_o = (count_q != Q_CNT_W'(Q_DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_valid_o && rd_ready_i;
  assign rd_job_o   = slot_mem[rd_ptr_q];

  // Store incoming jobs
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem[wr_ptr_q] <= wr_job_i;
    end
  end

  // Advance pointers and track occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_PTR_W'(1);
      end
      case ({wr_en, rd_en})
        2'b10:   count_q <= count_q + Q_CNT_W'(1);
        2'b01:   count_q <= count_q - Q_CNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/maf_divider.sv =====
// ----------------------------------------------------------------------------
// Moving average filter divider
// Restoring divider, one quotient bit per cycle, its final step waiting for a
// free registered result, which holds while the receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module maf_divider
  import maf_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  job_t           job_i,
  input  wire logic      job_valid_i,
  output logic           job_ready_o,
  output logic [AVG_W-1:0] average_o,
  output logic           average_valid_o,
  input  wire logic      average_ready_i
);

  typedef enum logic {
    DIV_IDLE,
    DIV_RUN
  } div_state_e;

  div_state_e         state_q;
  logic [STEP_W-1:0]  step_q;
  logic [SUM_W-1:0]   quo_q, quo_d;
  logic [CNT_W-1:0]   rem_q, rem_d;
  logic [CNT_W-1:0]   div_q;
  logic [CNT_W:0]     trial;
  logic [CNT_W:0]     diff;
  logic               ge;
  logic               last_step;
  logic               out_free;
  logic               step_en;
  logic [AVG_W-1:0]   out_q;
  logic               out_valid_q;

  assign job_ready_o     = (state_q == DIV_IDLE);
  assign average_o       = out_q;
  assign average_valid_o = out_valid_q;

  // One restoring step: shift in the next dividend bit and try a subtract
  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = (trial >= {1'b0, div_q});
  assign rem_d = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
  assign quo_d = {quo_q[SUM_W-2:0], ge};

  assign last_step = (step_q == STEP_W'(SUM_W - 1));
  assign out_free  = !out_valid_q || average_ready_i;
  // Hold the final step until the result register can take it
  assign step_en   = (state_q == DIV_RUN) && (!last_step || out_free);

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (job_valid_i && job_ready_o) begin
      quo_q <= job_i.sum;
      rem_q <= '0;
      div_q <= job_i.cnt;
    end else if (step_en) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
    if (step_en && last_step) begin
      out_q <= quo_d[AVG_W-1:0];
    end
  end

  // Sequence the divider and the result handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= DIV_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Raise valid on the final step, drop it once the word is taken
      if (step_en && last_step) begin
        out_valid_q <= 1'b1;
      end else if (average_valid_o && average_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        DIV_IDLE: begin
          if (job_valid_i) begin
            state_q <= DIV_RUN;
            step_q  <= '0;
          end
        end
        DIV_RUN: begin
          if (step_en) begin
            if (last_step) begin
              state_q <= DIV_IDLE;
            end else begin
              step_q <= step_q + STEP_W'(1);
            end
          end
        end
        default: begin
          state_q <= DIV_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/moving_average_filter_core.sv =====
// ----------------------------------------------------------------------------
// Moving average filter core
// Sliding-window mean of an unsigned sample stream.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the sample channel (sample_i, valid/ready); each one
//   yields exactly one average on the average channel, in order. The average
//   is the running sum of the last WINDOW samples divided by the number of
//   samples held, truncated, so during warm-up it divides by fewer.
//   The front end reads the ring slot on accept, then updates the sum and
//   pushes the job; a 2-entry job queue follows; the restoring divider
//   loads the job, then steps through the dividend, one quotient bit each
//   step. The front end keeps taking samples while the divider works,
//   until the queue fills, so the divider sets the sustained rate.
//   Reset clears the running sum, slot and fill count; the ring memory needs
//   no clearing pass since the fill count masks entries never written.
//   When the receiver stalls the average holds in its output register, the
//   divider waits on its last step, the queue fills and then sample_ready_o
//   drops; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module moving_average_filter_core
  import maf_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [SAMPLE_W-1:0] sample_i,
  input  wire logic                sample_valid_i,
  output logic                     sample_ready_o,
  output logic [AVG_W-1:0]         average_o,
  output logic                     average_valid_o,
  input  wire logic                average_ready_i
);

  job_t front_job;
  logic front_valid;
  logic front_ready;
  job_t back_job;
  logic back_valid;
  logic back_ready;

  // Accept samples and build division jobs
  maf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_i       (sample_i),
    .sample_valid_i (sample_valid_i),
    .sample_ready_o (sample_ready_o),
    .job_o          (front_job),
    .job_valid_o    (front_valid),
    .job_ready_i    (front_ready)
  );

  // Decouple front and divider
  maf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_job_i   (front_job),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .rd_job_o   (back_job),
    .rd_valid_o (back_valid),
    .rd_ready_i (back_ready)
  );

  // Divide and deliver averages
  maf_divider u_divider (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_i           (back_job),
    .job_valid_i     (back_valid),
    .job_ready_o     (back_ready),
    .average_o       (average_o),
    .average_valid_o (average_valid_o),
    .average_ready_i (average_ready_i)
  );

endmodule

`default_nettype wire

// ===== rtl/core/maf_checker.sv =====
// ----------------------------------------------------------------------------
// Moving average filter port checker
// Tracks words in flight at the ports and checks output hold, no invented words and capacity.
// ----------------------------------------------------------------------------
`default_nettype none

`include "moving_average_filter_core_assert.svh"

module maf_checker
  import maf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             sample_valid_i,
  input  wire logic             sample_ready_o,
  input  wire logic [AVG_W-1:0] average_o,
  input  wire logic             average_valid_o,
  input  wire logic             average_ready_i
);

  // Front, queue, divider and output register each hold words
  localparam int unsigned MaxInFlight = Q_DEPTH + 3;
  localparam int unsigned FlightW     = $clog2(MaxInFlight + 1);

  logic [FlightW-1:0] flight_q;
  logic               in_acc;
  logic               out_acc;

  assign in_acc  = sample_valid_i && sample_ready_o;
  assign out_acc = average_valid_o && average_ready_i;

  // Count words accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flight_q <= '0;
    end else begin
      case ({in_acc, out_acc})
        2'b10:   flight_q <= flight_q + FlightW'(1);
        2'b01:   flight_q <= flight_q - FlightW'(1);
        default: flight_q <= flight_q;
      endcase
    end
  end

  `MAF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, average_valid_o && !average_ready_i,
                   average_valid_o && $stable(average_o))

  `MAF_ASSERT_IMPL(a_no_invented, clk_i, rst_ni, average_valid_o, flight_q != '0)

  `MAF_ASSERT_IMPL(a_capacity, clk_i, rst_ni, 1'b1, flight_q <= FlightW'(MaxInFlight))

  `MAF_ASSERT_IMPL(a_full_stalls, clk_i, rst_ni, flight_q == FlightW'(MaxInFlight),
                   !sample_ready_o)

endmodule

bind moving_average_filter_core maf_checker u_maf_checker (.*);

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// Moving average filter core testbench
// Drives a stream of 16-bit samples into the core with random idling on both
// sides and one long output stall. A local copy of the sample ring, running
// sum, slot and fill count predicts each average, and every average that
// leaves the core is checked in order against that prediction.
// ----------------------------------------------------------------------------
module tb;
  import maf_pkg::*;

  localparam int unsigned HALF_PERIOD    = 4;
  localparam int unsigned RESET_CYCLES   = 10;
  localparam int unsigned IDLE_PERCENT   = 34;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 40;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic [SAMPLE_W-1:0] sample_i        = '0;
  logic                sample_valid_i  = 1'b0;
  logic                sample_ready_o;
  logic [AVG_W-1:0]    average_o;
  logic                average_valid_o;
  logic                average_ready_i = 1'b0;

  // Window model: ring, running sum, next slot and number of samples held
  logic [SAMPLE_W-1:0] window_samples [WINDOW];
  logic [SUM_W-1:0]    window_sum   = '0;
  logic [SLOT_W-1:0]   next_slot    = '0;
  logic [CNT_W-1:0]    samples_held = '0;
  logic [AVG_W-1:0]    expected_averages [$];
  logic [AVG_W-1:0]    wanted_average;

  // Idling controls and back-pressure requests
  bit sender_idles   = 1'b1;
  bit receiver_idles = 1'b1;
  int hold_requests  = 0;
  int holds_served   = 0;
  int hold_left      = 0;

  int failures    = 0;
  int quiet_count = 0;

  moving_average_filter_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .sample_i        (sample_i),
    .sample_valid_i  (sample_valid_i),
    .sample_ready_o  (sample_ready_o),
    .average_o       (average_o),
    .average_valid_o (average_valid_o),
    .average_ready_i (average_ready_i)
  );

  // Clock
  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  initial begin
    for (int i = 0; i < WINDOW; i++) window_samples[i] = '0;
  end

  // Update the window model with an accepted sample and queue its average
  task automatic predict_average(input logic [SAMPLE_W-1:0] fresh);
    logic [SUM_W-1:0] quotient;
    window_sum = window_sum - SUM_W'(window_samples[next_slot]) + SUM_W'(fresh);
    window_samples[next_slot] = fresh;
    if (samples_held < CNT_W'(WINDOW)) samples_held = samples_held + 1'b1;
    next_slot = (next_slot == SLOT_W'(WINDOW - 1)) ? '0 : next_slot + 1'b1;
    quotient = window_sum / SUM_W'(samples_held);
    expected_averages.push_back(quotient[AVG_W-1:0]);
  endtask

  // Offer one sample word and hold it until the core takes it
  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    bit idled;
    idled = 1'b0;
    while (sender_idles && ($urandom_range(0, 99) < IDLE_PERCENT)) begin
      if (!idled) sample_valid_i <= 1'b0;
      idled = 1'b1;
      @(posedge clk_i);
    end
    sample_i       <= value;
    sample_valid_i <= 1'b1;
    do @(posedge clk_i); while (!sample_ready_o);
    predict_average(value);
  endtask

  // Random sample biased towards the edges of the range
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return SAMPLE_W'($urandom_range(0, 15));
      3:       return SAMPLE_W'($urandom_range(65520, 65535));
      4:       return SAMPLE_W'(1) << $urandom_range(0, SAMPLE_W - 1);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Send a mix of single random samples and constant runs at least as long as the ring
  task automatic send_random_words(input int count);
    logic [SAMPLE_W-1:0] level;
    int run;
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 19) == 0) begin
        level = pick_sample();
        run   = $urandom_range(WINDOW, 2 * WINDOW);
        for (int i = 0; i < run && sent < count; i++) begin
          send_sample(level);
          sent++;
        end
      end else begin
        send_sample(pick_sample());
        sent++;
      end
    end
  endtask

  // Warm-up: divisor grows with each sample until the ring is full
  task automatic test_warm_up();
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0001);
    send_sample(16'hFFFE);
    repeat (WINDOW - 4) send_sample(16'hFFFF);
  endtask

  // Full-scale sum once the slot wraps, then evict it again
  task automatic test_full_scale_wrap();
    repeat (4) send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'h0000);
  endtask

  task automatic test_random_mix();
    send_random_words(600);
  endtask

  // Long stretch with no idling on either side
  task automatic test_streaming();
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    send_random_words(300);
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
  endtask

  // Hold the output off while samples keep coming, so the input stalls
  task automatic test_back_pressure();
    sender_idles = 1'b0;
    hold_requests++;
    send_random_words(40);
    sender_idles = 1'b1;
  endtask

  task automatic test_random_tail();
    send_random_words(460);
  endtask

  // Receiver: random ready, or a counted hold when one is requested
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      average_ready_i <= 1'b0;
      hold_left       <= 0;
    end else if (hold_left > 0) begin
      average_ready_i <= 1'b0;
      hold_left       <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      average_ready_i <= 1'b0;
      hold_left       <= HOLD_CYCLES - 1;
      holds_served    <= holds_served + 1;
    end else if (receiver_idles) begin
      average_ready_i <= ($urandom_range(0, 99) >= IDLE_PERCENT);
    end else begin
      average_ready_i <= 1'b1;
    end
  end

  // Check each average word against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && average_valid_o && average_ready_i) begin
      if (expected_averages.size() == 0) begin
        $error("average: unexpected word, actual %0d", average_o);
        failures++;
      end else begin
        wanted_average = expected_averages.pop_front();
        if (average_o !== wanted_average) begin
          $error("average: expected %0d, actual %0d", wanted_average, average_o);
          failures++;
        end
      end
    end
  end

  // Watchdog: end the run if no word moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((sample_valid_i && sample_ready_o) || (average_valid_o && average_ready_i)) begin
        quiet_count <= 0;
      end else if (quiet_count + 1 >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_count <= quiet_count + 1;
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_warm_up();
    test_full_scale_wrap();
    test_random_mix();
    test_streaming();
    test_back_pressure();
    test_random_tail();
    sample_valid_i <= 1'b0;

    // Drain outstanding averages, then allow for the core's latency
    while (expected_averages.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (failures == 0 && expected_averages.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
